/* sv/aeg_pkg.sv */
package aeg_pkg;

    // sizes of the fields and of the internal arithmetic
    localparam int SAMPLE_WIDTH     = 16;
    localparam int TIME_FRAC_BITS   = 16;
    localparam int SINE_TABLE_DEPTH = 256;

    localparam int COUNT_W  = 24;
    localparam int ENV_W    = 17;
    localparam int TQ_W     = TIME_FRAC_BITS + 1;
    localparam int NUM_W    = COUNT_W + TIME_FRAC_BITS;
    localparam int DEN_W    = COUNT_W;
    localparam int QUO_W    = TIME_FRAC_BITS + 1;
    localparam int SINE_AW  = $clog2(SINE_TABLE_DEPTH);
    localparam int SINE_DW  = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [ENV_W-1:0]   ENV_ONE      = ENV_W'(65536);
    localparam logic [COUNT_W-1:0] COUNT_MAX    = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] DURATION_RST = COUNT_W'(48000);
    localparam longint unsigned    PI_HALF_Q30  = 64'd1686629713;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_SHAPE    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DURATION = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        SHAPE_SINE  = 2'd0,
        SHAPE_AD    = 2'd1,
        SHAPE_ASD   = 2'd2,
        SHAPE_UNITY = 2'd3
    } shape_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_T,
        ST_SHAPE,
        ST_DIV_D,
        ST_SINE,
        ST_MUL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_in;
        logic                           restart;
        logic                           block_last;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_out;
        logic [ENV_W-1:0]               envelope_value;
        logic                           last_in_block;
    } out_item_t;

    // divider handshake towards the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // quarter sine entry k, Q30 Taylor series up to x^13, rounded to 16 bits
    function automatic logic [SINE_DW-1:0] quarter_sine(input int k);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        v;
        x    = (PI_HALF_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
        x2   = (x * x) >> 30;
        sum  = $signed(x);
        term = ((x * x2) >> 30) / 6;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 20;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 42;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 72;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 110;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 156;
        sum  = sum + $signed(term);
        if (sum < 0) begin
            sum = 64'sd0;
        end
        v = ((64'(sum) * 64'd65536) + 64'd536870912) >> 30;
        if (v > 64'd65535) begin
            v = 64'd65535;
        end
        return v[SINE_DW-1:0];
    endfunction

endpackage

/* sv/aeg_divider.sv */
module aeg_divider (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [aeg_pkg::NUM_W-1:0]  numer,
    input  logic [aeg_pkg::DEN_W-1:0]  denom,
    output logic [aeg_pkg::QUO_W-1:0]  quotient,
    output aeg_pkg::div_status_t       status
);
    import aeg_pkg::*;

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [DEN_W-1:0] rem_reg,  rem_next;
    logic [QUO_W-1:0] low_reg,  low_next;
    logic [QUO_W-1:0] quo_reg,  quo_next;
    logic [DEN_W-1:0] den_reg,  den_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DEN_W:0]   trial;
    logic             fits;

    // one restoring step: shift in the next numerator bit, subtract if it fits
    assign trial = {rem_reg, low_reg[QUO_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            // the high part is below the divisor as the quotient fits QUO_W bits
            rem_next  = DEN_W'(numer[NUM_W-1:QUO_W]);
            low_next  = numer[QUO_W-1:0];
            quo_next  = '0;
            den_next  = denom;
            cnt_next  = CNT_W'(QUO_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            low_next = {low_reg[QUO_W-2:0], 1'b0};
            quo_next = {quo_reg[QUO_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

/* sv/aeg_sine_rom.sv */
module aeg_sine_rom (
    input  logic                        aclk,
    input  logic [aeg_pkg::SINE_AW-1:0] rd_addr,
    output logic [aeg_pkg::SINE_DW-1:0] rd_data
);
    import aeg_pkg::*;

    logic [SINE_DW-1:0] sine_rom [SINE_TABLE_DEPTH];
    logic [SINE_DW-1:0] rd_data_reg;

    // constant quarter sine, folded at elaboration
    for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_entry
        assign sine_rom[k] = quarter_sine(k);
    end

    // registered read
    always_ff @(posedge aclk) begin
        rd_data_reg <= sine_rom[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/audio_envelope_gain.sv */
// audio envelope gain: sample times a time-dependent envelope
// steps: take the item, divide the elapsed count by the duration unless past it, pick the shape,
// read the half sine table or run a second division for the 1/x decay, multiply, hold the result
// the serial divider gives one quotient bit a cycle, 17 bits per division
// a new item is taken only once the previous one has left ST_DONE; a waiting result holds the next at its end
// synchronous active-low reset: shape unity, duration 48000, elapsed count zero
module audio_envelope_gain (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  aeg_pkg::in_item_t              s_payload,
    output logic                           m_valid,
    input  logic                           m_ready,
    output aeg_pkg::out_item_t             m_payload,
    input  logic                           cfg_we,
    input  logic [aeg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [aeg_pkg::CFG_DATA_W-1:0] cfg_data
);
    import aeg_pkg::*;

    localparam int SW       = SAMPLE_WIDTH;
    localparam int F        = TIME_FRAC_BITS;
    localparam int P_W      = SINE_AW + 2;
    localparam int SH_R     = (F >= 16) ? F - 16 : 0;
    localparam int SH_L     = (F >= 16) ? 0 : 16 - F;
    localparam int PROD_W   = SW + ENV_W + 1;
    localparam logic [TQ_W-1:0] T_ONE = TQ_W'(1) << F;
    localparam logic signed [SW+1:0] S_MAX = (SW+2)'((1 << (SW - 1)) - 1);
    localparam logic signed [SW+1:0] S_MIN = -S_MAX - (SW+2)'(1);

    // scale a Q5.F value to Q1.16, truncating
    function automatic logic [ENV_W-1:0] to_q16(input logic [TQ_W+3:0] v);
        logic [TQ_W+3+SH_L:0] w;
        w = (TQ_W+4+SH_L)'(v >> SH_R) << SH_L;
        return w[ENV_W-1:0];
    endfunction

    state_t state_reg, state_next;

    shape_t              shape_reg;
    logic [COUNT_W-1:0]  dur_reg;
    logic [COUNT_W-1:0]  count_reg;

    logic signed [SW-1:0] sample_reg;
    logic                 last_reg;
    logic [TQ_W-1:0]      tq_reg;
    logic [ENV_W-1:0]     env_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic      m_valid_reg;
    out_item_t out_reg;

    logic               accept;
    logic               load_out;
    logic [COUNT_W-1:0] count_eff;
    logic               past_end;

    logic              div_start;
    logic              div_sel_decay;
    logic [NUM_W-1:0]  div_numer;
    logic [DEN_W-1:0]  div_denom;
    logic [QUO_W-1:0]  div_quo;
    div_status_t       div_stat;

    logic [TQ_W+3:0]   tq10;
    logic [TQ_W+3:0]   tq5;
    logic [TQ_W-1:0]   one_minus_tq;
    logic [TQ_W+3:0]   tq9;
    logic              in_attack;
    logic              in_sustain;

    logic [TQ_W+P_W-1:0] pos_wide;
    logic [P_W-1:0]      pos;
    logic [P_W-1:0]      mirror;
    logic                sine_peak;
    logic [SINE_AW-1:0]  sine_addr;
    logic [SINE_DW-1:0]  sine_data;

    logic signed [PROD_W-1:0] prod_round;
    logic signed [SW+1:0]     q_full;
    logic signed [SW-1:0]     q_sat;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign load_out = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // elapsed count seen by this item and the end-of-duration test
    assign count_eff = s_payload.restart ? '0 : count_reg;
    assign past_end  = (dur_reg == '0) || (count_eff >= dur_reg);

    // segment tests on normalised time
    assign tq10         = {tq_reg, 3'b000} + {2'b00, tq_reg, 1'b0};
    assign tq5          = {2'b00, tq_reg, 2'b00} + {4'b0000, tq_reg};
    assign one_minus_tq = T_ONE - tq_reg;
    assign tq9          = {tq_reg, 3'b000} + {4'b0000, tq_reg};
    assign in_attack    = (tq10 < (TQ_W+4)'(T_ONE));
    assign in_sustain   = (tq5 < ((TQ_W+4)'(T_ONE) << 2));

    // half sine position and mirrored table index
    assign pos_wide  = {tq_reg, {P_W{1'b0}}} >> (F + 1);
    assign pos       = pos_wide[P_W-1:0];
    assign mirror    = P_W'(2 * SINE_TABLE_DEPTH) - pos;
    assign sine_peak = (pos == P_W'(SINE_TABLE_DEPTH));
    assign sine_addr = (pos < P_W'(SINE_TABLE_DEPTH)) ? pos[SINE_AW-1:0]
                                                      : mirror[SINE_AW-1:0];

    // shared divider: time value first, then the 1/x decay
    assign div_numer = div_sel_decay ? NUM_W'({one_minus_tq, 16'b0})
                                     : {count_eff, {F{1'b0}}};
    assign div_denom = div_sel_decay ? DEN_W'(tq9) : dur_reg;

    aeg_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .numer    (div_numer),
        .denom    (div_denom),
        .quotient (div_quo),
        .status   (div_stat)
    );

    aeg_sine_rom u_rom (
        .aclk    (aclk),
        .rd_addr (sine_addr),
        .rd_data (sine_data)
    );

    // sequencer state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // sequencer next state and divider control
    always_comb begin
        state_next    = state_reg;
        div_start     = 1'b0;
        div_sel_decay = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (past_end) begin
                        state_next = ST_SHAPE;
                    end else begin
                        div_start  = 1'b1;
                        state_next = ST_DIV_T;
                    end
                end
            end
            ST_DIV_T: begin
                if (div_stat.done) begin
                    state_next = ST_SHAPE;
                end
            end
            ST_SHAPE: begin
                div_sel_decay = 1'b1;
                unique case (shape_reg)
                    SHAPE_SINE: state_next = ST_SINE;
                    SHAPE_AD: begin
                        if (in_attack) begin
                            state_next = ST_MUL;
                        end else begin
                            div_start  = 1'b1;
                            state_next = ST_DIV_D;
                        end
                    end
                    SHAPE_ASD:   state_next = ST_MUL;
                    SHAPE_UNITY: state_next = ST_MUL;
                    default:     state_next = ST_MUL;
                endcase
            end
            ST_DIV_D: begin
                if (div_stat.done) begin
                    state_next = ST_MUL;
                end
            end
            ST_SINE: state_next = ST_MUL;
            ST_MUL:  state_next = ST_DONE;
            ST_DONE: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // configuration registers and elapsed count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shape_reg <= SHAPE_UNITY;
            dur_reg   <= DURATION_RST;
            count_reg <= '0;
        end else begin
            if (cfg_we && (cfg_index == REG_SHAPE)) begin
                shape_reg <= shape_t'(cfg_data[1:0]);
            end
            if (cfg_we && (cfg_index == REG_DURATION)) begin
                dur_reg <= cfg_data[COUNT_W-1:0];
            end
            if (accept) begin
                count_reg <= (count_eff == COUNT_MAX) ? COUNT_MAX
                                                      : count_eff + COUNT_W'(1);
            end
        end
    end

    // item datapath
    always_ff @(posedge aclk) begin
        if (accept) begin
            sample_reg <= s_payload.sample_in;
            last_reg   <= s_payload.block_last;
            tq_reg     <= T_ONE;
        end
        if ((state_reg == ST_DIV_T) && div_stat.done) begin
            tq_reg <= div_quo[TQ_W-1:0];
        end
        if (state_reg == ST_SHAPE) begin
            unique case (shape_reg)
                SHAPE_SINE:  env_reg <= ENV_ONE;
                SHAPE_AD:    env_reg <= to_q16(tq10);
                SHAPE_ASD: begin
                    if (in_attack) begin
                        env_reg <= to_q16(tq10);
                    end else if (in_sustain) begin
                        env_reg <= ENV_ONE;
                    end else begin
                        env_reg <= to_q16(tq5 - tq5 + (TQ_W+4)'(one_minus_tq) * (TQ_W+4)'(5));
                    end
                end
                SHAPE_UNITY: env_reg <= ENV_ONE;
                default:     env_reg <= ENV_ONE;
            endcase
        end
        if ((state_reg == ST_DIV_D) && div_stat.done) begin
            env_reg <= (div_quo > QUO_W'(ENV_ONE)) ? ENV_ONE : ENV_W'(div_quo);
        end
        if (state_reg == ST_SINE) begin
            env_reg <= sine_peak ? ENV_ONE : ENV_W'(sine_data);
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= PROD_W'(sample_reg) * $signed({1'b0, env_reg});
        end
    end

    // round half up and saturate
    assign prod_round = prod_reg + PROD_W'(32768);
    assign q_full     = prod_round[PROD_W-1:16];
    always_comb begin
        priority if (q_full > S_MAX) begin
            q_sat = S_MAX[SW-1:0];
        end else if (q_full < S_MIN) begin
            q_sat = S_MIN[SW-1:0];
        end else begin
            q_sat = q_full[SW-1:0];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_reg.sample_out     <= q_sat;
            out_reg.envelope_value <= env_reg;
            out_reg.last_in_block  <= last_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

endmodule

/* sv/aeg_checker.sv */
module aeg_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input aeg_pkg::out_item_t m_payload
);
    import aeg_pkg::*;

    // a held result keeps its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result changed while stalled");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // the sequencer is busy right after taking an item
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item taken while the previous one is at work");

    // gain never exceeds one
    a_env_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_payload.envelope_value <= ENV_ONE)
        else $error("envelope above one");

    // zero gain silences the sample
    a_zero_gain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_payload.envelope_value == '0) |-> m_payload.sample_out == '0)
        else $error("nonzero sample at zero gain");

endmodule

bind audio_envelope_gain aeg_checker u_aeg_checker (.*);
